// ----- hdl/lcs_pkg.sv -----
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, codes and widths of the looped command sequencer.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int DEPTH     = 64;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int MODE_W    = 3;
  localparam int TYPE_W    = 4;
  localparam int PAYLOAD_W = 32;
  localparam int REP_W     = 8;
  localparam int LEN_W     = 6;
  localparam int AVAIL_W   = 14;
  localparam logic [AVAIL_W-1:0] LEFT_MAX = {AVAIL_W{1'b1}};

  // Input modes
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXTRA  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_URGENT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

  // Command types
  localparam logic [TYPE_W-1:0] TYPE_NONE   = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_FLAP   = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_FILTER = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_WAIT   = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_SAVE   = 4'd4;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [IDX_W-1:0]     entry_index;
    logic [TYPE_W-1:0]    cmd_type;
    logic [PAYLOAD_W-1:0] cmd_payload;
    logic [IDX_W-1:0]     loop_begin;
    logic [IDX_W-1:0]     loop_end;
    logic [REP_W-1:0]     loop_repeats;
    logic [LEN_W-1:0]     sequence_length;
  } in_item_t;

  typedef struct packed {
    logic                 status;
    logic [TYPE_W-1:0]    out_type;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [AVAIL_W-1:0]   available;
  } out_item_t;

  // One program entry, also the layout of a pending slot
  typedef struct packed {
    logic [TYPE_W-1:0]    cmd_type;
    logic [PAYLOAD_W-1:0] cmd_payload;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic [REP_W-1:0] repeats;
  } loop_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    entry_t           wdata;
  } mem_req_t;

endpackage

// ----- hdl/lcs_stream_if.sv -----
// ----------------------------------------------------------------------------
// lcs_stream_if
// Valid/ready channel carrying one item of a configurable type.
// ----------------------------------------------------------------------------
interface lcs_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/lcs_prog_mem.sv -----
// ----------------------------------------------------------------------------
// lcs_prog_mem
// Program memory: one shared address, write or read, registered read data.
// ----------------------------------------------------------------------------
module lcs_prog_mem (
  input  logic              clk,
  input  lcs_pkg::mem_req_t req,
  output lcs_pkg::entry_t   rdata
);

  lcs_pkg::entry_t mem [lcs_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    // hold read data between reads
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ----- hdl/lcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer control: decodes items, walks the program on start, pops
// commands, and owns loop, index, count and slot registers.
// ----------------------------------------------------------------------------
module lcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  lcs_pkg::in_item_t  cmd_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output lcs_pkg::out_item_t rsp_data,
  output lcs_pkg::mem_req_t  mem_req,
  input  lcs_pkg::entry_t    mem_rdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_START = 2'd3;

  localparam int IW = lcs_pkg::IDX_W;
  localparam int AW = lcs_pkg::AVAIL_W;

  logic [1:0]                state, state_next;
  lcs_pkg::in_item_t         item, item_next;
  lcs_pkg::loop_t            hdr, hdr_next;
  lcs_pkg::loop_t            act, act_next;
  logic [IW-1:0]             cur, cur_next;
  logic [AW-1:0]             left, left_next;
  lcs_pkg::entry_t           urg, urg_next;
  lcs_pkg::entry_t           ext, ext_next;
  logic [IW-1:0]             scan_idx, scan_idx_next;
  logic                      scan_bad, scan_bad_next;
  lcs_pkg::out_item_t        rsp_data_next;
  logic                      out_load;
  logic                      accept;
  logic                      out_free;
  logic                      type_ok;
  logic [IW:0]               loop_len;
  logic [IW+lcs_pkg::REP_W:0] loop_total;
  logic [AW+1:0]             start_total;
  logic [AW:0]               avail_sum;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign type_ok   = (mem_rdata.cmd_type == lcs_pkg::TYPE_FLAP) ||
                     (mem_rdata.cmd_type == lcs_pkg::TYPE_FILTER) ||
                     (mem_rdata.cmd_type == lcs_pkg::TYPE_WAIT);

  assign loop_len    = (hdr.repeats != '0) ?
                       ({1'b0, hdr.last} - {1'b0, hdr.first} + (IW+1)'(1)) : '0;
  assign loop_total  = (IW+lcs_pkg::REP_W+1)'(loop_len) *
                       (IW+lcs_pkg::REP_W+1)'(hdr.repeats);
  assign start_total = (AW+2)'(item.sequence_length) + (AW+2)'(loop_total);

  always_comb begin
    state_next    = state;
    item_next     = item;
    hdr_next      = hdr;
    act_next      = act;
    cur_next      = cur;
    left_next     = left;
    urg_next      = urg;
    ext_next      = ext;
    scan_idx_next = scan_idx;
    scan_bad_next = scan_bad;
    mem_req       = '0;
    out_load      = 1'b0;
    rsp_data_next = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          item_next    = cmd_data;
          mem_req.re   = 1'b1;
          mem_req.addr = (cmd_data.mode == lcs_pkg::MODE_START) ? '0 : cur;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item.mode == lcs_pkg::MODE_START) begin
          // header type is in the read data now
          if (mem_rdata.cmd_type != lcs_pkg::TYPE_SAVE) begin
            scan_bad_next = 1'b1;
            state_next    = S_START;
          end else if (item.sequence_length == '0) begin
            scan_bad_next = 1'b0;
            state_next    = S_START;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.addr  = IW'(1);
            scan_idx_next = IW'(1);
            state_next    = S_SCAN;
          end
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          unique case (item.mode)
            lcs_pkg::MODE_WRITE: begin
              mem_req.we                = 1'b1;
              mem_req.addr              = item.entry_index;
              mem_req.wdata.cmd_type    = item.cmd_type;
              mem_req.wdata.cmd_payload = item.cmd_payload;
              if (item.entry_index == '0) begin
                hdr_next.first   = item.loop_begin;
                hdr_next.last    = item.loop_end;
                hdr_next.repeats = item.loop_repeats;
              end
            end
            lcs_pkg::MODE_EXTRA: begin
              ext_next.cmd_type    = item.cmd_type;
              ext_next.cmd_payload = item.cmd_payload;
            end
            lcs_pkg::MODE_URGENT: begin
              urg_next.cmd_type    = item.cmd_type;
              urg_next.cmd_payload = item.cmd_payload;
            end
            lcs_pkg::MODE_POP: begin
              priority if (urg.cmd_type != lcs_pkg::TYPE_NONE) begin
                rsp_data_next.out_type    = urg.cmd_type;
                rsp_data_next.out_payload = urg.cmd_payload;
                urg_next.cmd_type         = lcs_pkg::TYPE_NONE;
              end else if (ext.cmd_type != lcs_pkg::TYPE_NONE) begin
                rsp_data_next.out_type    = ext.cmd_type;
                rsp_data_next.out_payload = ext.cmd_payload;
                ext_next.cmd_type         = lcs_pkg::TYPE_NONE;
              end else if (left == '0) begin
                rsp_data_next.status = 1'b1;
              end else begin
                rsp_data_next.out_type    = mem_rdata.cmd_type;
                rsp_data_next.out_payload = mem_rdata.cmd_payload;
                left_next                 = left - AW'(1);
                if (act.first != '0 && act.last != '0 && cur == act.last &&
                    act.repeats != '0) begin
                  cur_next         = act.first;
                  act_next.repeats = act.repeats - lcs_pkg::REP_W'(1);
                end else begin
                  cur_next = cur + IW'(1);
                end
                if (left_next == '0) begin
                  cur_next = IW'(1);
                end
              end
            end
            lcs_pkg::MODE_CLEAR: begin
              act_next = '0;
              cur_next = IW'(1);
              left_next = '0;
              urg_next = '0;
              ext_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!type_ok) begin
          scan_bad_next = 1'b1;
          state_next    = S_START;
        end else if (scan_idx == IW'(item.sequence_length)) begin
          scan_bad_next = 1'b0;
          state_next    = S_START;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.addr  = scan_idx + IW'(1);
          scan_idx_next = scan_idx + IW'(1);
        end
      end
      S_START: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (scan_bad) begin
            rsp_data_next.status = 1'b1;
          end else begin
            // loop registers load even when the marks turn out bad
            act_next = hdr;
            if (hdr.first > hdr.last || hdr.last > IW'(item.sequence_length)) begin
              rsp_data_next.status = 1'b1;
            end else begin
              cur_next  = IW'(1);
              left_next = (start_total > (AW+2)'(lcs_pkg::LEFT_MAX)) ?
                          lcs_pkg::LEFT_MAX : start_total[AW-1:0];
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    avail_sum = (AW+1)'(left_next) +
                (AW+1)'(urg_next.cmd_type != lcs_pkg::TYPE_NONE) +
                (AW+1)'(ext_next.cmd_type != lcs_pkg::TYPE_NONE);
    rsp_data_next.available = (avail_sum > (AW+1)'(lcs_pkg::LEFT_MAX)) ?
                              lcs_pkg::LEFT_MAX : avail_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      act       <= '0;
      cur       <= IW'(1);
      left      <= '0;
      urg       <= '0;
      ext       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      act   <= act_next;
      cur   <= cur_next;
      left  <= left_next;
      urg   <= urg_next;
      ext   <= ext_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    hdr      <= hdr_next;
    scan_idx <= scan_idx_next;
    scan_bad <= scan_bad_next;
    if (out_load) begin
      rsp_data <= rsp_data_next;
    end
  end

endmodule

// ----- hdl/looped_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// looped_command_sequencer
// Command program sequencer with a looped program and two priority slots.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per transfer (mode plus its fields); rsp returns
//   exactly one result per item, in order, from an output register.
//   Write entries (entry 0 is the header with the loop marks), start a
//   sequence, load the urgent or extraordinary slot, then pop with read-next.
// Timing:
//   Every mode except start reads the program memory on transfer, then
//   updates state and loads the output once the output register is free.
//   Start reads the header and then each program entry through the single
//   memory port, one per cycle, and stops at a bad header or at the first
//   bad entry. One item is in flight at a time; cmd.ready is low while it
//   is worked on.
// Stall:
//   A result waits in the output register while rsp.ready is low, and the
//   pending item holds there until the register frees.
// Reset:
//   Slots empty, no commands left, index at one; rsp.valid drops. Program
//   memory and header keep no reset value and need writing before use.
// ----------------------------------------------------------------------------
module looped_command_sequencer (
  input  logic          clk,
  input  logic          rst,
  lcs_stream_if.sink    cmd,
  lcs_stream_if.source  rsp
);

  lcs_pkg::mem_req_t mem_req;
  lcs_pkg::entry_t   mem_rdata;

  lcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_data  (cmd.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  lcs_prog_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

// ----- hdl/lcs_checker.sv -----
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks of the command sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lcs_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input lcs_pkg::out_item_t rsp_data
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped or changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // one item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("input taken while an item is in flight");

  // an error never carries a command
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status |->
      rsp_data.out_type == lcs_pkg::TYPE_NONE && rsp_data.out_payload == '0)
    else $error("error result carries a command");

endmodule

bind looped_command_sequencer lcs_checker u_lcs_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ----- tb/tb_looped_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_looped_command_sequencer
// Self-checking bench for the looped command sequencer. Directed items cover
// empty pops, both priority slots, loop replay and every start error. Random
// program/start/pop sequences with noise follow. Both channels idle at
// random, and the response side holds off once so the block stalls.
// ----------------------------------------------------------------------------
module tb_looped_command_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import lcs_pkg::*;

  localparam int N_ITEMS        = 750;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_LIMIT    = 5000;

  // Tracks program memory, loop state and slots; queues one response per command.
  class sequencer_scoreboard;
    logic [TYPE_W-1:0]    prog_type    [DEPTH];
    logic [PAYLOAD_W-1:0] prog_payload [DEPTH];
    bit                   written      [DEPTH];
    loop_t                header;
    loop_t                active;
    logic [IDX_W-1:0]     cur_index;
    int unsigned          cmds_left;
    entry_t               urgent;
    entry_t               extra;
    out_item_t            pending_rsp[$];
    int unsigned          errors;

    function new();
      foreach (written[i]) written[i] = 1'b0;
      header = '0;
      errors = 0;
      clear_run();
    endfunction

    function void clear_run();
      active    = '0;
      cur_index = IDX_W'(1);
      cmds_left = 0;
      urgent    = '0;
      extra     = '0;
    endfunction

    function logic [AVAIL_W-1:0] available_now();
      int unsigned n;
      n = cmds_left + (urgent.cmd_type != TYPE_NONE) + (extra.cmd_type != TYPE_NONE);
      return (n > LEFT_MAX) ? LEFT_MAX : AVAIL_W'(n);
    endfunction

    function bit start_run(logic [LEN_W-1:0] len);
      int unsigned span;
      int unsigned total;
      logic [TYPE_W-1:0] t;
      if (prog_type[0] != TYPE_SAVE) return 1'b0;
      for (int i = 1; i <= len; i++) begin
        t = prog_type[i % DEPTH];
        if (t != TYPE_FLAP && t != TYPE_FILTER && t != TYPE_WAIT) return 1'b0;
      end
      // loop marks take effect even when they turn out to be bad
      active = header;
      if (active.first > active.last || active.last > len) return 1'b0;
      cur_index = IDX_W'(1);
      span      = (active.repeats != 0) ? active.last - active.first + 1 : 0;
      total     = len + span * active.repeats;
      cmds_left = (total > LEFT_MAX) ? LEFT_MAX : total;
      return 1'b1;
    endfunction

    // Turn a command that would read a never-written entry into a write of it.
    function in_item_t guarded(in_item_t c);
      if (c.mode == MODE_START) begin
        if (!written[0]) begin
          c.mode        = MODE_WRITE;
          c.entry_index = '0;
          c.cmd_type    = TYPE_SAVE;
          return c;
        end
        for (int i = 1; i <= c.sequence_length; i++) begin
          if (!written[i % DEPTH]) begin
            c.mode        = MODE_WRITE;
            c.entry_index = IDX_W'(i);
            c.cmd_type    = TYPE_W'($urandom_range(1, 3));
            return c;
          end
        end
      end else if (c.mode == MODE_POP && urgent.cmd_type == TYPE_NONE &&
                   extra.cmd_type == TYPE_NONE && cmds_left != 0 && !written[cur_index]) begin
        c.mode        = MODE_WRITE;
        c.entry_index = cur_index;
        c.cmd_type    = TYPE_W'($urandom_range(1, 3));
      end
      return c;
    endfunction

    function void take_command(in_item_t c);
      out_item_t r;
      r = '0;
      case (c.mode)
        MODE_WRITE: begin
          prog_type[c.entry_index]    = c.cmd_type;
          prog_payload[c.entry_index] = c.cmd_payload;
          written[c.entry_index]      = 1'b1;
          if (c.entry_index == 0) begin
            header.first   = c.loop_begin;
            header.last    = c.loop_end;
            header.repeats = c.loop_repeats;
          end
        end
        MODE_START:  r.status = !start_run(c.sequence_length);
        MODE_EXTRA:  extra  = '{cmd_type: c.cmd_type, cmd_payload: c.cmd_payload};
        MODE_URGENT: urgent = '{cmd_type: c.cmd_type, cmd_payload: c.cmd_payload};
        MODE_POP: begin
          if (urgent.cmd_type != TYPE_NONE) begin
            r.out_type      = urgent.cmd_type;
            r.out_payload   = urgent.cmd_payload;
            urgent.cmd_type = TYPE_NONE;
          end else if (extra.cmd_type != TYPE_NONE) begin
            r.out_type     = extra.cmd_type;
            r.out_payload  = extra.cmd_payload;
            extra.cmd_type = TYPE_NONE;
          end else if (cmds_left == 0) begin
            r.status = 1'b1;
          end else begin
            r.out_type    = prog_type[cur_index];
            r.out_payload = prog_payload[cur_index];
            cmds_left--;
            // jump back only with both marks set and repeats left
            if (active.first != 0 && active.last != 0 && cur_index == active.last &&
                active.repeats != 0) begin
              cur_index = active.first;
              active.repeats--;
            end else begin
              cur_index++;
            end
            if (cmds_left == 0) cur_index = IDX_W'(1);
          end
        end
        MODE_CLEAR: clear_run();
        default: ;
      endcase
      r.available = available_now();
      pending_rsp.push_back(r);
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with nothing pending: %p", $time, got);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.out_type !== want.out_type) begin
        $display("%0t: out_type expected %0d got %0d", $time, want.out_type, got.out_type);
        errors++;
      end
      if (got.out_payload !== want.out_payload) begin
        $display("%0t: out_payload expected %h got %h", $time, want.out_payload,
                 got.out_payload);
        errors++;
      end
      if (got.available !== want.available) begin
        $display("%0t: available expected %0d got %0d", $time, want.available,
                 got.available);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lcs_stream_if #(.item_t(in_item_t))  cmd ();
  lcs_stream_if #(.item_t(out_item_t)) rsp ();

  looped_command_sequencer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  sequencer_scoreboard sb = new();

  int unsigned n_sent;
  bit          steady;
  bit          holdoff_go;
  bit          holdoff_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Response side: random stalls, one long hold-off
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_go && !holdoff_done) begin
        rsp.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
        holdoff_done = 1'b1;
      end else begin
        rsp.ready <= steady || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_response(rsp.data);
  end

  function automatic in_item_t any_item();
    in_item_t c;
    c.mode            = MODE_W'($urandom_range(0, 5));
    c.entry_index     = IDX_W'($urandom);
    c.cmd_type        = TYPE_W'($urandom);
    c.cmd_payload     = $urandom;
    c.loop_begin      = IDX_W'($urandom);
    c.loop_end        = IDX_W'($urandom);
    c.loop_repeats    = REP_W'($urandom);
    c.sequence_length = LEN_W'($urandom);
    return c;
  endfunction

  function automatic in_item_t item_of(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                                       logic [TYPE_W-1:0] t, logic [PAYLOAD_W-1:0] p);
    in_item_t c;
    c             = any_item();
    c.mode        = m;
    c.entry_index = idx;
    c.cmd_type    = t;
    c.cmd_payload = p;
    return c;
  endfunction

  // Hold valid across back-to-back transfers; drop it only for an idle gap.
  task automatic send(in_item_t c);
    c = sb.guarded(c);
    while (!steady && $urandom_range(0, 99) < 21) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.data  <= c;
    do @(posedge clk); while (!cmd.ready);
    sb.take_command(c);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic simple(logic [MODE_W-1:0] m);
    in_item_t c;
    c      = any_item();
    c.mode = m;
    send(c);
  endtask

  task automatic write_header(int b, int e, int r);
    in_item_t c;
    c              = item_of(MODE_WRITE, '0, TYPE_SAVE, $urandom);
    c.loop_begin   = IDX_W'(b);
    c.loop_end     = IDX_W'(e);
    c.loop_repeats = REP_W'(r);
    send(c);
  endtask

  task automatic start_seq(int len);
    in_item_t c;
    c                 = any_item();
    c.mode            = MODE_START;
    c.sequence_length = LEN_W'(len);
    send(c);
  endtask

  task automatic load_slot();
    in_item_t c;
    c      = any_item();
    c.mode = $urandom_range(0, 1) ? MODE_URGENT : MODE_EXTRA;
    if ($urandom_range(0, 4) == 0) c.cmd_type = TYPE_NONE;
    send(c);
  endtask

  task automatic directed();
    send(item_of(MODE_POP, '0, '0, '0));
    send(item_of(MODE_URGENT, '0, TYPE_NONE, '1));
    send(item_of(MODE_EXTRA, '1, 4'hF, '1));
    send(item_of(MODE_URGENT, '1, 4'hF, '0));
    repeat (3) simple(MODE_POP);
    write_header(2, 3, 1);
    send(item_of(MODE_WRITE, 6'd1, TYPE_FLAP, '0));
    send(item_of(MODE_WRITE, 6'd2, TYPE_FILTER, '1));
    send(item_of(MODE_WRITE, 6'd3, TYPE_WAIT, 32'h5A5A_A5A5));
    send(item_of(MODE_WRITE, 6'd4, TYPE_FLAP, 32'h8000_0001));
    start_seq(4);
    send(item_of(MODE_EXTRA, '0, TYPE_WAIT, 32'hDEAD_0001));
    repeat (3) simple(MODE_POP);
    // bad marks mid-run: loop registers change, the count does not
    write_header(3, 2, 255);
    start_seq(4);
    repeat (5) simple(MODE_POP);
    send(item_of(MODE_WRITE, '1, 4'hF, '1));
    write_header(0, 63, 0);
    start_seq(4);
    send(item_of(MODE_WRITE, 6'd2, TYPE_NONE, '0));
    write_header(1, 1, 1);
    start_seq(4);
    send(item_of(MODE_WRITE, '0, 4'd5, '0));
    start_seq(0);
    write_header(0, 0, 0);
    start_seq(0);
    simple(MODE_POP);
    simple(MODE_CLEAR);
  endtask

  task automatic run_program();
    int len;
    int b;
    int e;
    int r;
    int pick;
    int pops;
    if ($urandom_range(0, 99) < 8)
      len = ($urandom_range(0, 2) == 0) ? 63 : $urandom_range(40, 62);
    else
      len = $urandom_range(0, 10);
    pick = $urandom_range(0, 9);
    if (pick < 6 && len > 0) begin
      e = $urandom_range(1, len);
      b = $urandom_range(1, e);
    end else if (pick < 8) begin
      b = 0;
      e = $urandom_range(0, len);
    end else begin
      b = $urandom_range(0, 63);
      e = $urandom_range(0, 63);
    end
    pick = $urandom_range(0, 9);
    r = (pick < 7) ? $urandom_range(0, 3) : (pick < 9) ? $urandom_range(4, 20)
                                                        : $urandom_range(0, 255);
    write_header(b, e, r);
    for (int i = 1; i <= len; i++) begin
      send(item_of(MODE_WRITE, IDX_W'(i),
                   TYPE_W'(($urandom_range(0, 99) < 4) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 3)),
                   $urandom));
    end
    if ($urandom_range(0, 9) == 0) load_slot();
    start_seq(len);
    pops = sb.cmds_left + 2 + $urandom_range(0, 2);
    if (pops > 80) pops = 80;
    repeat (pops) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) load_slot();
      else if (pick < 10) simple(MODE_CLEAR);
      else simple(MODE_POP);
    end
    if ($urandom_range(0, 3) == 0) simple(MODE_CLEAR);
  endtask

  initial begin
    rst       <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.data  <= '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    directed();
    while (n_sent < N_ITEMS) begin
      steady = (n_sent >= 300 && n_sent < 420);
      if (n_sent >= 550) holdoff_go = 1'b1;
      if ($urandom_range(0, 99) < 75) begin
        run_program();
      end else begin
        repeat ($urandom_range(1, 6)) send(any_item());
      end
    end
    cmd.valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && sb.pending_rsp.size() != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (sb.pending_rsp.size() != 0)
        $display("%0t: %0d responses never arrived", $time, sb.pending_rsp.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- looped_command_sequencer.f -----
hdl/lcs_pkg.sv
hdl/lcs_stream_if.sv
hdl/lcs_prog_mem.sv
hdl/lcs_ctrl.sv
hdl/looped_command_sequencer.sv
hdl/lcs_checker.sv
tb/tb_looped_command_sequencer.sv
